/* rtl/core/prefixed_varint_decoder_core_defines.svh */
// Assertion helpers for the prefixed varint decoder core.
// Both expect clk in the scope of use; PVD_ASSERT also expects arst_n.
`ifndef PREFIXED_VARINT_DECODER_CORE_DEFINES_SVH
`define PREFIXED_VARINT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PVD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PVD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVD_ASSERT(label, prop, msg)
`define PVD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/core/pvd_pkg.sv */
package pvd_pkg;

	localparam int VALUE_W = 57;
	localparam int USED_W  = 4;
	localparam int GC_W    = 4;
	localparam int PW_W    = 4;

	localparam logic [7:0]      BYTE_ONES  = 8'hFF;
	localparam logic [6:0]      GROUP_MASK = 7'd127;
	localparam int              CONT_BIT   = 7;
	localparam logic [PW_W-1:0] PW_MAX     = 4'd8;

	// classified item handed from the front to the back
	typedef struct packed {
		logic       start;       // prefix-bearing first byte
		logic       prefix_done; // prefix below its mask: integer ends here
		logic       last;        // buffer end after this byte
		logic [7:0] byte_val;    // masked prefix on a start byte, raw byte otherwise
	} pvd_op_t;

	typedef struct packed {
		logic               overflow;
		logic               complete;
		logic [USED_W-1:0]  used;
		logic [VALUE_W-1:0] value;
	} pvd_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pvd_qstat_t;

endpackage

/* rtl/core/prefixed_varint_decoder_core.sv */
// Prefixed varint decoder core: one byte per item, one result per finished integer.
// Throughput: one item per cycle while the output is not stalled; a two-entry queue sits between intake and execution.
// Result path: an accepted item is written to the queue, then read from it, and its result goes to the output register.
// The execute unit adds one shifted 7-bit group to the 57-bit accumulator per cycle while extension bytes are popped.
// Reset: arst_n low clears the queue, the accumulator, the group count and output valid.
`include "prefixed_varint_decoder_core_defines.svh"

module prefixed_varint_decoder_core #(
	parameter int MAX_EXT_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [11:8] prefix_bits, [15:12] zero
	input  logic        s_axis_tuser,  // [0] start_req
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [56:0] value, [60:57] bytes_used, [63:61] zero
	output logic [1:0]  m_axis_tuser   // [0] complete, [1] overflow
);

	pvd_pkg::pvd_qstat_t qstat;
	pvd_pkg::pvd_op_t    wr_op;
	pvd_pkg::pvd_op_t    rd_op;
	pvd_pkg::pvd_res_t   res;
	logic                push;
	logic                pop;

	pvd_front u_front (
		.in_valid    (s_axis_tvalid),
		.data_byte   (s_axis_tdata[7:0]),
		.start_req   (s_axis_tuser),
		.prefix_bits (s_axis_tdata[11:8]),
		.buffer_end  (s_axis_tlast),
		.qstat       (qstat),
		.in_ready    (s_axis_tready),
		.push        (push),
		.op          (wr_op)
	);

	pvd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (wr_op),
		.pop    (pop),
		.rd_op  (rd_op),
		.qstat  (qstat)
	);

	pvd_back #(
		.MAX_EXT_BYTES (MAX_EXT_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (rd_op),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {3'b000, res.used, res.value};
	assign m_axis_tuser = {res.overflow, res.complete};

	`PVD_ASSERT(a_queue_sane, !(qstat.full && qstat.empty), "queue full and empty at once")
	`PVD_ASSERT(a_flags_exclusive, m_axis_tvalid |-> !(res.complete && res.overflow), "complete with overflow")
	`PVD_ASSERT(a_used_range, m_axis_tvalid |-> (res.used != 4'd0 && res.used <= 4'(MAX_EXT_BYTES + 1)), "bytes_used out of range")
	`PVD_ASSERT(a_overflow_count, (m_axis_tvalid && res.overflow) |-> (res.used == 4'(MAX_EXT_BYTES + 1)), "overflow before limit")

endmodule

/* rtl/core/pvd_front.sv */
module pvd_front (
	input  logic                             in_valid,
	input  logic [7:0]                       data_byte,
	input  logic                             start_req,
	input  logic [pvd_pkg::PW_W-1:0]         prefix_bits,
	input  logic                             buffer_end,
	input  pvd_pkg::pvd_qstat_t              qstat,
	output logic                             in_ready,
	output logic                             push,
	output pvd_pkg::pvd_op_t                 op
);

	logic [pvd_pkg::PW_W-1:0] pw;
	logic [7:0]               mask;
	logic [7:0]               prefix_val;

	always_comb begin
		pw = (prefix_bits > pvd_pkg::PW_MAX) ? pvd_pkg::PW_MAX : prefix_bits;
		mask = pvd_pkg::BYTE_ONES >> (pvd_pkg::PW_MAX - pw);
		prefix_val = data_byte & mask;
	end

	assign in_ready = !qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		op.start       = start_req;
		op.prefix_done = (prefix_val != mask);
		op.last        = buffer_end;
		op.byte_val    = start_req ? prefix_val : data_byte;
	end

endmodule

/* rtl/core/pvd_fifo.sv */
module pvd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pvd_pkg::pvd_op_t    wr_op,
	input  logic                pop,
	output pvd_pkg::pvd_op_t    rd_op,
	output pvd_pkg::pvd_qstat_t qstat
);

	pvd_pkg::pvd_op_t mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_op;
		end
	end

	assign rd_op       = mem[rd_ptr_q];
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/core/pvd_back.sv */
module pvd_back #(
	parameter int MAX_EXT_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pvd_pkg::pvd_op_t    op,
	input  pvd_pkg::pvd_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output pvd_pkg::pvd_res_t   res
);

	logic [pvd_pkg::VALUE_W-1:0] acc_q;
	logic [pvd_pkg::GC_W-1:0]    gc_q;
	logic                        busy_q;
	logic                        out_valid_q;
	pvd_pkg::pvd_res_t           res_q;

	logic [pvd_pkg::VALUE_W-1:0] group_ext;
	logic [5:0]                  shift;
	logic [pvd_pkg::VALUE_W-1:0] sum;
	logic [pvd_pkg::GC_W-1:0]    gc_next;
	logic                        emit;
	pvd_pkg::pvd_res_t           res_d;

	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	always_comb begin
		group_ext = {{(pvd_pkg::VALUE_W-7){1'b0}}, op.byte_val[6:0] & pvd_pkg::GROUP_MASK};
		shift     = {3'b000, gc_q[2:0]} * 6'd7;
		sum       = acc_q + (group_ext << shift);
		gc_next   = gc_q + 1'b1;
		emit      = 1'b0;
		res_d     = '0;
		if (op.start) begin
			res_d.value = {{(pvd_pkg::VALUE_W-8){1'b0}}, op.byte_val};
			res_d.used  = pvd_pkg::USED_W'(1);
			if (op.prefix_done) begin
				emit           = 1'b1;
				res_d.complete = 1'b1;
			end else if (op.last) begin
				emit = 1'b1;
			end
		end else if (busy_q) begin
			res_d.value = sum;
			res_d.used  = gc_next + 1'b1;
			if (!op.byte_val[pvd_pkg::CONT_BIT]) begin
				emit           = 1'b1;
				res_d.complete = 1'b1;
			end else if (gc_next >= pvd_pkg::GC_W'(MAX_EXT_BYTES)) begin
				// overflow wins over buffer end on the same byte
				emit           = 1'b1;
				res_d.overflow = 1'b1;
			end else if (op.last) begin
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			gc_q        <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or hold the waiting one until it is taken
			out_valid_q <= (pop && emit) || (out_valid_q && !out_ready);
			if (pop) begin
				if (op.start) begin
					acc_q  <= {{(pvd_pkg::VALUE_W-8){1'b0}}, op.byte_val};
					gc_q   <= '0;
					busy_q <= !emit;
				end else if (busy_q) begin
					acc_q  <= sum;
					gc_q   <= gc_next;
					busy_q <= !emit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* test/tb_prefixed_varint_decoder_core.sv */
`timescale 1ns / 1ps

module tb_prefixed_varint_decoder_core;
	import pvd_pkg::*;

	localparam int EXT_MAX     = 8;
	localparam int RAND_ITEMS  = 1100;
	localparam int CALM_ITEMS  = 950;
	localparam int STALL_LIMIT = 2000;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RES} chk_t;

	typedef struct packed {
		logic [7:0]      b;
		logic            st;
		logic [PW_W-1:0] pw;
		logic            be;
		chk_t            kind;
		pvd_res_t        res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] data_byte, [11:8] prefix_bits, [15:12] zero
	logic        s_axis_tuser = 1'b0; // [0] start_req
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [63:0] m_axis_tdata;       // [56:0] value, [60:57] bytes_used, [63:61] zero
	logic [1:0]  m_axis_tuser;       // [0] complete, [1] overflow

	// decoder state as the stream has left it
	logic [VALUE_W-1:0] dec_acc = '0;
	logic [GC_W-1:0]    dec_groups = '0;
	bit                 dec_busy = 1'b0;

	pvd_res_t pending_ints[$];
	int       n_errors = 0;
	int       n_taken = 0;
	int       gap_pct = 0;
	int       stall_pct = 0;
	int       idle_cycles = 0;

	prefixed_varint_decoder_core #(
		.MAX_EXT_BYTES(EXT_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Advance the decoder by one byte; returns 1 when an integer is finished.
	function automatic bit decode_byte(input logic [7:0] b, input logic st,
			input logic [PW_W-1:0] pw, input logic be, output pvd_res_t res);
		int         eff;
		logic [7:0] mask;
		logic [7:0] pfx;
		bit         done;
		logic       cpl;
		logic       ovf;
		done = 1'b0;
		cpl = 1'b0;
		ovf = 1'b0;
		res = '0;
		if (st) begin
			eff = (pw > PW_MAX) ? int'(PW_MAX) : int'(pw);
			mask = BYTE_ONES >> (8 - eff);
			pfx = b & mask;
			dec_acc = VALUE_W'(pfx);
			dec_groups = '0;
			dec_busy = 1'b1;
			cpl = (pfx < mask);
			done = cpl || be;
		end else if (dec_busy) begin
			if (7 * int'(dec_groups) < VALUE_W)
				dec_acc = dec_acc + (VALUE_W'(b & GROUP_MASK) << (7 * int'(dec_groups)));
			dec_groups = dec_groups + 1'b1;
			if (!b[CONT_BIT]) begin
				done = 1'b1;
				cpl = 1'b1;
			end else if (dec_groups >= EXT_MAX) begin
				done = 1'b1;
				ovf = 1'b1;
			end else begin
				done = be;
			end
		end
		if (done) begin
			res.value = dec_acc;
			res.used = dec_groups + 1'b1;
			res.complete = cpl;
			res.overflow = ovf;
			dec_busy = 1'b0;
		end
		return done;
	endfunction

	function automatic row_t dir_row(input logic [7:0] b, input logic st,
			input logic [PW_W-1:0] pw, input logic be, input chk_t kind,
			input logic [VALUE_W-1:0] value, input logic [USED_W-1:0] used,
			input logic cpl, input logic ovf);
		row_t r;
		r.b = b;
		r.st = st;
		r.pw = pw;
		r.be = be;
		r.kind = kind;
		r.res.value = value;
		r.res.used = used;
		r.res.complete = cpl;
		r.res.overflow = ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		n_errors++;
	endtask

	// Send one byte, wait for its handshake, then record what it should produce.
	task automatic feed(input logic [7:0] b, input logic st, input logic [PW_W-1:0] pw,
			input logic be, input chk_t kind, input pvd_res_t typed);
		pvd_res_t res;
		bit       taken;
		bit       got;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, pw, b};
		s_axis_tuser <= st;
		s_axis_tlast <= be;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		taken = st || dec_busy;
		got = decode_byte(b, st, pw, be, res);
		if (kind == CHK_MODEL && got)
			pending_ints.push_back(res);
		else if (kind == CHK_RES)
			pending_ints.push_back(typed);
		if (taken)
			n_taken++;
	endtask

	// wait until every result is in; the caller holds the input idle
	task automatic drain();
		do @(posedge clk); while (pending_ints.size() != 0);
	endtask

	// One integer: prefix byte, then a run of continuation bytes when the prefix is full.
	task automatic send_random_int();
		logic [PW_W-1:0] pw;
		logic [7:0]      b;
		logic [7:0]      mask;
		int              eff;
		int              n;
		if ($urandom_range(0, 9) == 0)
			pw = PW_W'($urandom_range(0, 15));
		else
			pw = PW_W'($urandom_range(1, 8));
		eff = (pw > PW_MAX) ? int'(PW_MAX) : int'(pw);
		mask = BYTE_ONES >> (8 - eff);
		b = 8'($urandom);
		if ($urandom_range(0, 3) != 0)
			b = b | mask;
		feed(b, 1'b1, pw, ($urandom_range(0, 15) == 0), CHK_MODEL, '0);
		if ((b & mask) != mask)
			return;
		// runs of nine or ten bytes reach the overflow
		n = $urandom_range(1, 10);
		for (int i = 1; i <= n; i++) begin
			b = 8'($urandom);
			b[CONT_BIT] = (i < n);
			if ($urandom_range(0, 24) == 0)
				b[CONT_BIT] = ~b[CONT_BIT];
			feed(b, 1'b0, PW_W'($urandom), ($urandom_range(0, 19) == 0), CHK_MODEL, '0);
		end
	endtask

	// receiver stalls
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		pvd_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ints.size() == 0) begin
				report_mismatch("result with none pending", m_axis_tdata, 0);
			end else begin
				want = pending_ints.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== want.value)
					report_mismatch("value", m_axis_tdata[VALUE_W-1:0], want.value);
				if (m_axis_tdata[VALUE_W+USED_W-1:VALUE_W] !== want.used)
					report_mismatch("bytes_used", m_axis_tdata[VALUE_W+USED_W-1:VALUE_W],
						want.used);
				if (m_axis_tuser[0] !== want.complete)
					report_mismatch("complete", m_axis_tuser[0], want.complete);
				if (m_axis_tuser[1] !== want.overflow)
					report_mismatch("overflow", m_axis_tuser[1], want.overflow);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		bit   paused;
		paused = 1'b0;

		rows.push_back(dir_row(8'hFF, 1'b0, 4'd8, 1'b1, CHK_NONE, 0, 0, 0, 0)); // idle, no start
		rows.push_back(dir_row(8'h00, 1'b1, 4'd8, 1'b0, CHK_RES, 0, 1, 1, 0));
		rows.push_back(dir_row(8'hFE, 1'b1, 4'd8, 1'b1, CHK_RES, 254, 1, 1, 0));
		rows.push_back(dir_row(8'h00, 1'b1, 4'd1, 1'b0, CHK_RES, 0, 1, 1, 0));
		// zero-width prefix always continues
		rows.push_back(dir_row(8'hFF, 1'b1, 4'd0, 1'b0, CHK_NONE, 0, 0, 0, 0));
		rows.push_back(dir_row(8'h05, 1'b0, 4'd3, 1'b0, CHK_RES, 5, 2, 1, 0));
		// 1337 with a 5-bit prefix, last byte also at buffer end
		rows.push_back(dir_row(8'h1F, 1'b1, 4'd5, 1'b0, CHK_NONE, 0, 0, 0, 0));
		rows.push_back(dir_row(8'h9A, 1'b0, 4'd5, 1'b0, CHK_NONE, 0, 0, 0, 0));
		rows.push_back(dir_row(8'h0A, 1'b0, 4'd5, 1'b1, CHK_RES, 1337, 3, 1, 0));
		// prefix width above eight, cut off on the start byte
		rows.push_back(dir_row(8'hFF, 1'b1, 4'd15, 1'b1, CHK_RES, 255, 1, 0, 0));
		rows.push_back(dir_row(8'h0F, 1'b1, 4'd4, 1'b0, CHK_MODEL, 0, 0, 0, 0));
		rows.push_back(dir_row(8'hFF, 1'b0, 4'd4, 1'b1, CHK_MODEL, 0, 0, 0, 0));
		// longest run: overflow wins over buffer end on the last byte
		rows.push_back(dir_row(8'hFF, 1'b1, 4'd8, 1'b0, CHK_MODEL, 0, 0, 0, 0));
		for (int i = 0; i < EXT_MAX - 1; i++)
			rows.push_back(dir_row(8'hFF, 1'b0, 4'd0, 1'b0, CHK_MODEL, 0, 0, 0, 0));
		rows.push_back(dir_row(8'hFF, 1'b0, 4'd0, 1'b1, CHK_RES, 57'h100_0000_0000_00FE,
			9, 0, 1));
		// restart while busy drops the open integer
		rows.push_back(dir_row(8'h07, 1'b1, 4'd3, 1'b0, CHK_MODEL, 0, 0, 0, 0));
		rows.push_back(dir_row(8'h85, 1'b0, 4'd3, 1'b0, CHK_MODEL, 0, 0, 0, 0));
		rows.push_back(dir_row(8'h01, 1'b1, 4'd2, 1'b0, CHK_RES, 1, 1, 1, 0));
		rows.push_back(dir_row(8'h01, 1'b1, 4'd1, 1'b1, CHK_RES, 1, 1, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			feed(rows[i].b, rows[i].st, rows[i].pw, rows[i].be, rows[i].kind, rows[i].res);
		s_axis_tvalid <= 1'b0;
		drain();

		n_taken = 0;
		while (n_taken < RAND_ITEMS) begin
			if (n_taken >= CALM_ITEMS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 40;
				endcase
			end
			if (!paused && n_taken >= RAND_ITEMS / 2) begin
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				drain();
			end
			if ($urandom_range(0, 9) == 0)
				feed(8'($urandom), ($urandom_range(0, 3) == 0), PW_W'($urandom), 1'($urandom),
					CHK_MODEL, '0);
			else
				send_random_int();
		end
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pvd_pkg.sv
rtl/core/pvd_front.sv
rtl/core/pvd_fifo.sv
rtl/core/pvd_back.sv
rtl/core/prefixed_varint_decoder_core.sv
test/tb_prefixed_varint_decoder_core.sv
